@@ rtl/ple_pkg.sv @@
package ple_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned LEN_W  = 11;

  // Request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_READ     = 3'd0,
    OP_INS_HEAD = 3'd1,
    OP_INS_TAIL = 3'd2,
    OP_INS_AT   = 3'd3,
    OP_DELETE   = 3'd4
  } opcode_e;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Resolved kind of work for one item
  typedef enum logic [2:0] {
    K_READ,
    K_HEAD,
    K_TAIL,
    K_MID,
    K_DEL
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_VAL,
    S_ALLOC,
    S_LINK,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         item_index;
    logic signed [DATA_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         list_length;
  } rsp_t;

endpackage

@@ rtl/ple_ram.sv @@
module ple_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/positional_list_engine.sv @@
// Channel  | Direction | Handshake                 | Payload
// request  | in        | in_valid_i / in_stall_o   | in_data_i  (ple_pkg::req_t)
// result   | out       | out_valid_o / out_stall_i | out_data_o (ple_pkg::rsp_t)
//
// One item at a time. Read, delete and insert at a position p walk the list from the
// head, following one link per cycle through the link memory's single read port. Head
// and tail inserts need no walk; refused or out-of-range items skip the memories.
// Reset is immediate: never-used slots are tracked by a fill mark, so no
// clearing pass. The result register lets the next item enter while a result
// is stalled; the sequencer waits only when a second result finds it still full.
module positional_list_engine #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ple_pkg::req_t in_data_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output ple_pkg::rsp_t out_data_o,
  input  logic          out_stall_i
);

  import ple_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = (PW > IDX_W) ? PW : IDX_W;
  localparam logic [PW-1:0] NULL_SLOT = PW'(CAPACITY);

  // Control state
  state_e state_q, state_d;
  logic [PW-1:0] first_q, first_d;
  logic [PW-1:0] last_q, last_d;
  logic [PW-1:0] free_q, free_d;
  logic [PW-1:0] fresh_q, fresh_d;
  logic [PW-1:0] len_q, len_d;
  logic          out_valid_q, out_valid_d;

  // Per-item working registers
  kind_e                    kind_q, kind_d;
  logic [PW-1:0]            cur_q, cur_d;
  logic [PW-1:0]            prev_q, prev_d;
  logic [PW-1:0]            nxt_q, nxt_d;
  logic [PW-1:0]            lnk_q, lnk_d;
  logic [PW-1:0]            cnt_q, cnt_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic signed [DATA_W-1:0] rd_q, rd_d;
  status_e                  st_q, st_d;
  rsp_t                     out_q, out_d;

  // Memory ports
  logic              link_we;
  logic [AW-1:0]     link_waddr;
  logic [PW-1:0]     link_wdata;
  logic [AW-1:0]     link_raddr;
  logic [PW-1:0]     link_rdata;
  logic              val_we;
  logic [AW-1:0]     val_waddr;
  logic [DATA_W-1:0] val_wdata;
  logic [AW-1:0]     val_raddr;
  logic [DATA_W-1:0] val_rdata;

  logic [CW-1:0] pos_c;
  logic [CW-1:0] len_c;
  logic          full;
  logic          accept;

  ple_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (PW)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  ple_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pos_c = CW'(in_data_i.item_index);
  assign len_c = CW'(len_q);
  assign full  = (len_q == NULL_SLOT);

  // Sequencer: decode, walk, update memories, deliver result
  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    last_d      = last_q;
    free_d      = free_q;
    fresh_d     = fresh_q;
    len_d       = len_q;
    kind_d      = kind_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    lnk_d       = lnk_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    rd_d        = rd_q;
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    link_we    = 1'b0;
    link_waddr = free_q[AW-1:0];
    link_wdata = NULL_SLOT;
    link_raddr = cur_q[AW-1:0];
    val_we     = 1'b0;
    val_waddr  = free_q[AW-1:0];
    val_wdata  = val_q;
    val_raddr  = cur_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d = in_data_i.item_value;
          rd_d  = '1;
          st_d  = ST_DONE;
          cur_d  = first_q;
          prev_d = NULL_SLOT;
          cnt_d  = PW'(pos_c);
          state_d = S_FIN;
          case (opcode_e'(in_data_i.opcode))
            OP_READ: begin
              if (pos_c >= len_c) begin
                st_d = ST_RANGE;
              end else begin
                kind_d     = K_READ;
                link_raddr = first_q[AW-1:0];
                state_d    = S_WALK;
              end
            end
            OP_INS_HEAD: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                kind_d     = K_HEAD;
                link_raddr = free_q[AW-1:0];
                state_d    = S_ALLOC;
              end
            end
            OP_INS_TAIL: begin
              if (full) begin
                st_d = ST_FULL;
              end else begin
                kind_d     = K_TAIL;
                prev_d     = last_q;
                link_raddr = free_q[AW-1:0];
                state_d    = S_ALLOC;
              end
            end
            OP_INS_AT: begin
              if (pos_c > len_c) begin
                st_d = ST_RANGE;
              end else if (full) begin
                st_d = ST_FULL;
              end else if (pos_c == '0) begin
                kind_d     = K_HEAD;
                link_raddr = free_q[AW-1:0];
                state_d    = S_ALLOC;
              end else if (pos_c == len_c) begin
                kind_d     = K_TAIL;
                prev_d     = last_q;
                link_raddr = free_q[AW-1:0];
                state_d    = S_ALLOC;
              end else begin
                // walk to the predecessor of the new element
                kind_d     = K_MID;
                cnt_d      = PW'(pos_c - CW'(1));
                link_raddr = first_q[AW-1:0];
                state_d    = S_WALK;
              end
            end
            OP_DELETE: begin
              if (pos_c >= len_c) begin
                st_d = ST_RANGE;
              end else begin
                kind_d     = K_DEL;
                link_raddr = first_q[AW-1:0];
                state_d    = S_WALK;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_WALK: begin
        // link_rdata holds the link of cur_q here
        if (cnt_q == '0) begin
          case (kind_q)
            K_READ: begin
              val_raddr = cur_q[AW-1:0];
              state_d   = S_VAL;
            end
            K_MID: begin
              prev_d     = cur_q;
              nxt_d      = link_rdata;
              link_raddr = free_q[AW-1:0];
              state_d    = S_ALLOC;
            end
            K_DEL: begin
              // unlink cur_q and push it onto the free chain
              link_we    = 1'b1;
              link_waddr = cur_q[AW-1:0];
              link_wdata = free_q;
              free_d     = cur_q;
              len_d      = len_q - PW'(1);
              if (last_q == cur_q) begin
                last_d = prev_q;
              end
              if (prev_q == NULL_SLOT) begin
                first_d = link_rdata;
                state_d = S_FIN;
              end else begin
                lnk_d   = link_rdata;
                state_d = S_LINK;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end else begin
          // advance one link
          prev_d     = cur_q;
          cur_d      = link_rdata;
          cnt_d      = cnt_q - PW'(1);
          link_raddr = link_rdata[AW-1:0];
        end
      end

      S_VAL: begin
        rd_d    = val_rdata;
        state_d = S_FIN;
      end

      S_ALLOC: begin
        // take the head of the free chain; untouched slots link to the next one
        if (free_q == fresh_q) begin
          free_d  = free_q + PW'(1);
          fresh_d = fresh_q + PW'(1);
        end else begin
          free_d = link_rdata;
        end
        len_d      = len_q + PW'(1);
        val_we     = 1'b1;
        val_waddr  = free_q[AW-1:0];
        val_wdata  = val_q;
        link_we    = 1'b1;
        link_waddr = free_q[AW-1:0];
        state_d    = S_FIN;
        case (kind_q)
          K_HEAD: begin
            link_wdata = first_q;
            first_d    = free_q;
            if (last_q == NULL_SLOT) begin
              last_d = free_q;
            end
          end
          K_TAIL: begin
            link_wdata = NULL_SLOT;
            last_d     = free_q;
            if (prev_q == NULL_SLOT) begin
              first_d = free_q;
            end else begin
              lnk_d   = free_q;
              state_d = S_LINK;
            end
          end
          K_MID: begin
            link_wdata = nxt_q;
            lnk_d      = free_q;
            state_d    = S_LINK;
          end
          default: begin
            link_we = 1'b0;
            val_we  = 1'b0;
          end
        endcase
      end

      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev_q[AW-1:0];
        link_wdata = lnk_q;
        state_d    = S_FIN;
      end

      S_FIN: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.read_value  = rd_q;
          out_d.status      = st_q;
          out_d.list_length = LEN_W'(len_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      first_q     <= NULL_SLOT;
      last_q      <= NULL_SLOT;
      free_q      <= '0;
      fresh_q     <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      last_q      <= last_d;
      free_q      <= free_d;
      fresh_q     <= fresh_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    nxt_q  <= nxt_d;
    lnk_q  <= lnk_d;
    cnt_q  <= cnt_d;
    val_q  <= val_d;
    rd_q   <= rd_d;
    st_q   <= st_d;
    out_q  <= out_d;
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import ple_pkg::*;

  localparam int unsigned LIST_CAP     = 1024;
  localparam int unsigned IDX_TOP      = (1 << IDX_W) - 1;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned FILL_ITEMS   = 300;
  localparam int unsigned MAX_GAP      = 17;
  localparam int unsigned QUIET_LIMIT  = 6000;
  localparam int unsigned DRAIN_CYCLES = LIST_CAP + 16;
  localparam int unsigned PRINT_CAP    = 50;

  // Opcodes the block leaves unassigned
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_NEG1 = -32'sd1;

  // How an item's fields are chosen
  typedef enum logic [1:0] {
    PICK_NONE,
    PICK_MIXED,
    PICK_FILL
  } pick_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_data_i   = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_data_o;
  logic out_stall_i = 1'b0;

  // Ordered list contents and the results still owed by the block
  logic signed [DATA_W-1:0] list_values[$];
  rsp_t                     owed_results[$];

  bit          idle_on = 1'b1;
  int unsigned err_count;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_full;
  int unsigned n_range;
  int unsigned n_random;
  int unsigned peak_len;
  int unsigned quiet_cycles;

  always #5 clk_i = ~clk_i;

  positional_list_engine #(
    .CAPACITY(LIST_CAP)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  function automatic int unsigned draw_gap();
    return idle_on ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  // Apply one request to the list and return the result it must produce
  function automatic rsp_t apply_request(req_t req);
    rsp_t        rsp;
    int unsigned len;
    int unsigned pos;
    len             = list_values.size();
    pos             = 32'(req.item_index);
    rsp.read_value  = VAL_NEG1;
    rsp.status      = ST_DONE;
    case (req.opcode)
      OP_READ: begin
        if (pos >= len) rsp.status = ST_RANGE;
        else rsp.read_value = list_values[pos];
      end
      OP_INS_HEAD: begin
        if (len >= LIST_CAP) rsp.status = ST_FULL;
        else list_values.push_front(req.item_value);
      end
      OP_INS_TAIL: begin
        if (len >= LIST_CAP) rsp.status = ST_FULL;
        else list_values.push_back(req.item_value);
      end
      OP_INS_AT: begin
        // range check wins over the full check
        if (pos > len) rsp.status = ST_RANGE;
        else if (len >= LIST_CAP) rsp.status = ST_FULL;
        else list_values.insert(pos, req.item_value);
      end
      OP_DELETE: begin
        if (pos >= len) rsp.status = ST_RANGE;
        else list_values.delete(pos);
      end
      default: ;
    endcase
    rsp.list_length = LEN_W'(list_values.size());
    return rsp;
  endfunction

  // Choose random fields from the current list length
  function automatic req_t pick_request(pick_e mode);
    req_t        req;
    int unsigned len;
    int unsigned roll;
    int unsigned hi;
    bit          in_range;
    len      = list_values.size();
    hi       = (len > IDX_TOP) ? IDX_TOP : len;
    in_range = ($urandom_range(0, 99) < 85);
    roll     = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 3))
        0:       req.item_value = VAL_MIN;
        1:       req.item_value = VAL_MAX;
        2:       req.item_value = '0;
        default: req.item_value = VAL_NEG1;
      endcase
    end else begin
      req.item_value = $urandom;
    end
    req.item_index = IDX_W'($urandom_range(0, IDX_TOP));
    if (mode == PICK_FILL) begin
      // mostly cheap end inserts, a few positional ones
      if (roll < 45) req.opcode = OP_INS_HEAD;
      else if (roll < 95) req.opcode = OP_INS_TAIL;
      else begin
        req.opcode     = OP_INS_AT;
        req.item_index = IDX_W'($urandom_range(0, hi));
      end
      return req;
    end
    if (roll < 4) begin
      case ($urandom_range(0, 2))
        0:       req.opcode = OP_SPARE_5;
        1:       req.opcode = OP_SPARE_6;
        default: req.opcode = OP_SPARE_7;
      endcase
      return req;
    end
    n_random++;
    if (roll < 24) begin
      req.opcode = OP_READ;
    end else if ($urandom_range(0, 99) < ((len < 8) ? 70 : (len > 96) ? 25 : 50)) begin
      case ($urandom_range(0, 2))
        0:       req.opcode = OP_INS_HEAD;
        1:       req.opcode = OP_INS_TAIL;
        default: req.opcode = OP_INS_AT;
      endcase
    end else begin
      req.opcode = OP_DELETE;
    end
    if (in_range) begin
      if (req.opcode == OP_INS_AT) req.item_index = IDX_W'($urandom_range(0, hi));
      else if (len != 0) req.item_index = IDX_W'($urandom_range(0, len - 1));
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t: %s mismatch, got %0h, want %0h", $time, what, got, want);
  endtask

  // Drive one item after a random gap and hold it until accepted
  task automatic send_request(logic [OP_W-1:0] op, int unsigned pos,
                              logic signed [DATA_W-1:0] val,
                              pick_e mode = PICK_NONE);
    req_t        req;
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    if (mode == PICK_NONE) begin
      req.opcode     = op;
      req.item_index = pos[IDX_W-1:0];
      req.item_value = val;
    end else begin
      req = pick_request(mode);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stall the result side for a random hold before each result while idling is on
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = draw_gap();
      @(negedge clk_i);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Check results first, then predict the accepted item, then watch for a hang
  always @(posedge clk_i) begin : monitor
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", out_data_o.read_value, '0);
        end else begin
          want = owed_results.pop_front();
          if (out_data_o.read_value !== want.read_value)
            report_mismatch("read_value", out_data_o.read_value, want.read_value);
          if (out_data_o.status !== want.status)
            report_mismatch("status", out_data_o.status, want.status);
          if (out_data_o.list_length !== want.list_length)
            report_mismatch("list_length", out_data_o.list_length, want.list_length);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        want = apply_request(in_data_i);
        owed_results.push_back(want);
        n_requests++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_RANGE) n_range++;
        if (32'(want.list_length) > peak_len) peak_len = 32'(want.list_length);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Out-of-range and unassigned requests on an empty list
  task automatic test_empty_list();
    send_request(OP_READ, 0, VAL_MAX);
    send_request(OP_DELETE, 0, VAL_MAX);
    send_request(OP_INS_AT, 1, VAL_MAX);
    send_request(OP_READ, IDX_TOP, '0);
    send_request(OP_SPARE_5, 0, '0);
    send_request(OP_SPARE_6, IDX_TOP, VAL_MIN);
    send_request(OP_SPARE_7, 0, VAL_NEG1);
  endtask

  // Every insert kind, value extremes, then read back each position
  task automatic test_insert_kinds();
    send_request(OP_INS_AT, 0, VAL_MIN);
    send_request(OP_INS_TAIL, IDX_TOP, VAL_MAX);
    send_request(OP_INS_HEAD, 0, '0);
    send_request(OP_INS_AT, 3, VAL_NEG1);
    send_request(OP_INS_AT, 2, 32'sd12345);
    send_request(OP_INS_AT, 6, 32'sd1);
    for (int i = 0; i <= 5; i++) send_request(OP_READ, i, '0);
  endtask

  // Delete at tail, middle and head, down to empty and back
  task automatic test_delete_kinds();
    send_request(OP_DELETE, 4, '0);
    send_request(OP_INS_TAIL, 0, 32'sd777);
    send_request(OP_READ, 4, '0);
    send_request(OP_DELETE, 2, '0);
    send_request(OP_DELETE, 0, '0);
    send_request(OP_DELETE, 5, '0);
    send_request(OP_DELETE, 2, '0);
    send_request(OP_DELETE, 1, '0);
    send_request(OP_DELETE, 0, '0);
    send_request(OP_INS_TAIL, 0, 32'sd42);
    send_request(OP_READ, 0, '0);
    send_request(OP_DELETE, 0, '0);
  endtask

  // Mixed traffic on a short list, with stretches free of idling
  task automatic test_random_ops();
    int unsigned block;
    block = 0;
    while (n_random < RANDOM_ITEMS) begin
      if (block % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
      block++;
      send_request(OP_READ, 0, '0, PICK_MIXED);
    end
    idle_on = 1'b1;
  endtask

  // Grow a long list, then work at its far positions
  task automatic test_long_list();
    int unsigned tail_pos;
    for (int k = 0; k < FILL_ITEMS; k++) send_request(OP_READ, 0, '0, PICK_FILL);
    tail_pos = list_values.size() - 1;
    send_request(OP_READ, tail_pos, '0);
    send_request(OP_READ, tail_pos / 2, '0);
    send_request(OP_READ, 0, '0);
    send_request(OP_READ, tail_pos + 1, '0);
    // drop the last element, then append behind the new tail
    send_request(OP_DELETE, tail_pos, '0);
    send_request(OP_INS_TAIL, 0, VAL_NEG1);
    send_request(OP_READ, tail_pos, '0);
    send_request(OP_INS_AT, tail_pos + 2, VAL_MAX);
    send_request(OP_INS_AT, tail_pos + 1, VAL_MAX);
    send_request(OP_READ, tail_pos + 1, '0);
    send_request(OP_DELETE, 0, '0);
    send_request(OP_INS_AT, 0, VAL_MIN);
    send_request(OP_DELETE, tail_pos / 2, '0);
    send_request(OP_INS_AT, tail_pos / 2, 32'sd99);
    send_request(OP_READ, tail_pos / 2, '0);
    send_request(OP_READ, IDX_TOP, '0);
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_insert_kinds();
    test_delete_kinds();
    test_random_ops();
    test_long_list();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Ran %0d requests, checked %0d results: %0d refused as full, %0d out of range",
             n_requests, n_results, n_full, n_range);
    $display("List grew to %0d of %0d slots; %0d mismatches", peak_len, LIST_CAP, err_count);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
